// ----- rtl/core/bba_pkg.sv -----
// Package for the block bitmap allocator: item and result beats, opcodes,
// status codes and the controller/datapath command and status structs.
// No dependencies.
package bba_pkg;

  // Fixed field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned BLK_W  = 12;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned CIDX_W = 2;

  // Map word geometry: 64 blocks per RAM word
  localparam int unsigned WORD_W = 64;
  localparam int unsigned BIT_W  = 6;

  // Operations
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK   = 2'd2;
  localparam logic [OP_W-1:0] OP_FORMAT = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_BLOCKS   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RESERVED = 2'd1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] BLOCKS_RST   = 13'd4096;
  localparam logic [CFG_W-1:0] RESERVED_RST = 13'd1;

  // Input beat
  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [BLK_W-1:0] target_block;
  } item_t;

  // Result beat
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [BLK_W-1:0] allocated_block;
  } result_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic            start_op;    // latch the item, issue first read
    logic            sweep;       // write one map word per cycle
    logic            sweep_zero;  // sweep writes zeros (reset clear)
    logic            scan;        // allocate scan step
    logic            rmw_wr;      // write back modified word (free/mark)
    logic            respond;     // load result register and strobe
    logic            rsp_grant;   // result carries the found index
    logic [ST_W-1:0] rsp_status;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic range_err;   // incoming target at or beyond block count
    logic count_zero;  // effective block count is zero
    logic sweep_last;  // sweep is at the last map word
    logic hit;         // scanned word holds a free block
    logic scan_miss;   // last scanned word holds none
  } sts_t;

endpackage

// ----- rtl/core/block_bitmap_allocator_top.sv -----
// Top level of the first-fit block bitmap allocator.
// Depends on bba_pkg, bba_ctrl, bba_dpath (and bba_ram below it).
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------
//  item     | item_i (operation, target_block)        | start high, busy low
//  result   | result_o (status, allocated_block)      | done_o, one cycle, no stall
//  config   | cfg_we_i, cfg_idx_i, cfg_wdata_i        | write at edge with cfg_we_i
//
// Allocate: one 64-bit map word read per cycle, stopping at the first word that
// holds a free block or at the last word of the count.
// Free / mark-used: read-modify-write of one word; errors are answered without touching the map.
// Format: one map word written per cycle.
// After reset the map is cleared a word per cycle, with busy high. Results
// cannot be held off by the receiver.
module block_bitmap_allocator_top
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  item_t             item_i,
  output logic              done_o,
  output result_t           result_o,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .op_i    (item_i.operation),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  bba_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o),
    .done_o      (done_o)
  );

endmodule

// ----- rtl/core/bba_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/bba_ctrl.sv -----
// Allocator controller: sequences reset clear, allocate scan, free/mark
// read-modify-write and format sweep. Depends on bba_pkg.
module bba_ctrl
  import bba_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] op_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o,
  output logic            busy_o
);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_SCAN = 5'b00100,
    S_RMW  = 5'b01000,
    S_FMT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_zero = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.start_op = 1'b1;
          unique case (op_i)
            OP_ALLOC: begin
              if (sts_i.count_zero) begin
                cmd_o.respond    = 1'b1;
                cmd_o.rsp_status = ST_NOSPACE;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_FREE, OP_MARK: begin
              if (sts_i.range_err) begin
                cmd_o.respond    = 1'b1;
                cmd_o.rsp_status = ST_RANGE;
              end else begin
                state_d = S_RMW;
              end
            end
            OP_FORMAT: state_d = S_FMT;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          cmd_o.respond    = 1'b1;
          cmd_o.rsp_grant  = 1'b1;
          cmd_o.rsp_status = ST_OK;
          state_d          = S_IDLE;
        end else if (sts_i.scan_miss) begin
          cmd_o.respond    = 1'b1;
          cmd_o.rsp_status = ST_NOSPACE;
          state_d          = S_IDLE;
        end
      end
      S_RMW: begin
        cmd_o.rmw_wr     = 1'b1;
        cmd_o.respond    = 1'b1;
        cmd_o.rsp_status = ST_OK;
        state_d          = S_IDLE;
      end
      S_FMT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.respond    = 1'b1;
          cmd_o.rsp_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  // State register; reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/bba_dpath.sv -----
// Allocator datapath: config registers, map RAM, address counter, first-zero
// search, word masks and result register. Depends on bba_pkg and bba_ram.
module bba_dpath
  import bba_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  item_t             item_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output result_t           result_o,
  output logic              done_o
);

  localparam int unsigned DEPTH = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EW    = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned XW    = EW + 1;

  // Configuration registers
  logic [CFG_W-1:0] blocks_q, reserved_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q   <= BLOCKS_RST;
      reserved_q <= RESERVED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BLOCKS:   blocks_q   <= cfg_wdata_i;
        REG_RESERVED: reserved_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective count and reservation, clipped to the map size
  logic [EW-1:0] cnt, res_eff, last_word;

  always_comb begin
    cnt = (EW'(blocks_q) > EW'(MAX_BLOCKS)) ? EW'(MAX_BLOCKS) : EW'(blocks_q);
    res_eff   = (EW'(reserved_q) > cnt) ? cnt : EW'(reserved_q);
    last_word = (cnt - EW'(1)) >> BIT_W;
  end

  // Mask of the bits of word w whose block index is below lim
  function automatic logic [WORD_W-1:0] word_mask(input logic [AW-1:0] w,
                                                  input logic [EW-1:0] lim);
    logic [XW-1:0] base, lim_x, diff;
    base  = XW'({w, {BIT_W{1'b0}}});
    lim_x = XW'(lim);
    diff  = lim_x - base;
    if (lim_x <= base) begin
      word_mask = '0;
    end else if (diff >= XW'(WORD_W)) begin
      word_mask = '1;
    end else begin
      word_mask = ~({WORD_W{1'b1}} << diff[BIT_W-1:0]);
    end
  endfunction

  // Latched item and scan state
  logic [OP_W-1:0]  op_q;
  logic [BLK_W-1:0] tgt_q;
  logic [AW:0]      addr_q, addr_d;
  logic             chk_valid_q, chk_valid_d;
  logic [AW-1:0]    chk_addr_q;

  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] rdata, wdata;
  logic              wr_en;

  logic              scan_more;
  logic [WORD_W-1:0] free_bits, tbit;
  logic              found;
  logic [BIT_W-1:0]  bitpos;

  // First free bit of the checked word, ignoring padding beyond the count
  always_comb begin
    free_bits = ~(rdata | ~word_mask(chk_addr_q, cnt));
    found     = |free_bits;
    bitpos    = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        bitpos = BIT_W'(i);
      end
    end
  end

  assign scan_more = (EW'(addr_q) <= last_word);
  assign tbit      = WORD_W'(1) << tgt_q[BIT_W-1:0];

  // Read address, next address and check pipeline
  always_comb begin
    rd_addr     = addr_q[AW-1:0];
    addr_d      = addr_q;
    chk_valid_d = 1'b0;
    if (cmd_i.start_op) begin
      if (item_i.operation == OP_ALLOC) begin
        rd_addr     = '0;
        addr_d      = (AW+1)'(1);
        chk_valid_d = 1'b1;
      end else begin
        rd_addr = AW'(item_i.target_block >> BIT_W);
        addr_d  = '0;
      end
    end else if (cmd_i.sweep) begin
      addr_d = addr_q + (AW+1)'(1);
    end else if (cmd_i.scan && scan_more && !(chk_valid_q && found)) begin
      addr_d      = addr_q + (AW+1)'(1);
      chk_valid_d = 1'b1;
    end
  end

  // Single write port: sweep, read-modify-write or allocate grant
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q[AW-1:0];
    wdata   = '0;
    if (cmd_i.sweep) begin
      wr_en = 1'b1;
      wdata = cmd_i.sweep_zero ? '0 : word_mask(addr_q[AW-1:0], res_eff);
    end else if (cmd_i.rmw_wr) begin
      wr_en   = 1'b1;
      wr_addr = AW'(tgt_q >> BIT_W);
      wdata   = (op_q == OP_MARK) ? (rdata | tbit) : (rdata & ~tbit);
    end else if (cmd_i.scan && chk_valid_q && found) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr_q;
      wdata   = rdata | (WORD_W'(1) << bitpos);
    end
  end

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Status to the controller
  always_comb begin
    sts_o.range_err  = (EW'(item_i.target_block) >= cnt);
    sts_o.count_zero = (cnt == '0);
    sts_o.sweep_last = (addr_q == (AW+1)'(DEPTH - 1));
    sts_o.hit        = chk_valid_q && found;
    sts_o.scan_miss  = chk_valid_q && !found && (EW'(chk_addr_q) == last_word);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      chk_valid_q <= 1'b0;
      done_o      <= 1'b0;
    end else begin
      addr_q      <= addr_d;
      chk_valid_q <= chk_valid_d;
      done_o      <= cmd_i.respond;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chk_addr_q <= rd_addr;
    if (cmd_i.start_op) begin
      op_q  <= item_i.operation;
      tgt_q <= item_i.target_block;
    end
    if (cmd_i.respond) begin
      result_o.status          <= cmd_i.rsp_status;
      result_o.allocated_block <= cmd_i.rsp_grant ? BLK_W'({chk_addr_q, bitpos}) : '0;
    end
  end

endmodule

// ----- rtl/core/bba_checker.sv -----
// Port-level checks of the block bitmap allocator, bound to the top level.
// Depends on bba_pkg and block_bitmap_allocator_top.
module bba_checker
  import bba_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input result_t result_o
);

  // An accepted beat either answers at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted item neither answered nor in progress");

  // A result follows an accepted beat or work in progress
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) || $past(start))
    else $error("result without an item");

  // Status stays within its defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.status == ST_OK || result_o.status == ST_RANGE ||
               result_o.status == ST_NOSPACE)
    else $error("undefined status code");

  // Errors carry a zero block index
  a_error_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != ST_OK |-> result_o.allocated_block == '0)
    else $error("error result with nonzero index");

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

// ----- test/tb_block_bitmap_allocator_top.sv -----
// Testbench for block_bitmap_allocator_top: a first-fit bitmap predictor checks
// every result beat. Directed corner cases come first, then random phases.
// Depends on bba_pkg and the RTL under rtl/core.
module tb_block_bitmap_allocator_top
  import bba_pkg::*;
();

  localparam int unsigned MAP_BLOCKS  = 4096;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_OPS   = 97;
  localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

  // DUT ports
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  item_t             item_i      = '0;
  logic              done_o;
  result_t           result_o;
  logic              cfg_we_i    = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;

  // Shadow of the occupancy map and the two registers
  logic [MAP_BLOCKS-1:0] used_map      = '0;
  logic [CFG_W-1:0]      blk_count_reg = BLOCKS_RST;
  logic [CFG_W-1:0]      rsv_count_reg = RESERVED_RST;

  item_t       queued_ops[$];
  result_t     map_replies[$];
  logic        beat_taken   = 1'b0;
  int unsigned gap_left     = 0;
  bit          idle_on      = 1'b1;
  int unsigned idle_pct     = 0;
  int unsigned ops_sent     = 0;
  int unsigned ops_taken    = 0;
  int unsigned stall_cycles = 0;
  int unsigned err_cnt      = 0;
  int unsigned op_seen[4]   = '{0, 0, 0, 0};
  int unsigned range_seen   = 0;
  int unsigned nospace_seen = 0;

  block_bitmap_allocator_top #(
    .MAX_BLOCKS(MAP_BLOCKS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Block count clipped to the map size
  function automatic int unsigned eff_count();
    return (blk_count_reg > MAP_BLOCKS) ? MAP_BLOCKS : int'(blk_count_reg);
  endfunction

  // Apply one operation to the shadow map and return the reply it gives
  function automatic result_t apply_map_op(item_t op_beat);
    result_t     r;
    int unsigned n_blk;
    int unsigned n_rsv;
    int unsigned i;
    bit          found;
    r       = '0;
    r.status = ST_OK;
    n_blk   = eff_count();
    found   = 1'b0;
    case (op_beat.operation)
      OP_ALLOC: begin
        r.status = ST_NOSPACE;
        for (i = 0; i < n_blk && !found; i++) begin
          if (!used_map[i]) begin
            used_map[i]       = 1'b1;
            r.status          = ST_OK;
            r.allocated_block = BLK_W'(i);
            found             = 1'b1;
          end
        end
      end
      OP_FREE, OP_MARK: begin
        if (op_beat.target_block >= n_blk) r.status = ST_RANGE;
        else used_map[op_beat.target_block] = (op_beat.operation == OP_MARK);
      end
      default: begin
        n_rsv    = (rsv_count_reg > n_blk) ? n_blk : int'(rsv_count_reg);
        used_map = '0;
        for (i = 0; i < n_rsv; i++) used_map[i] = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Random beat, mostly aimed at valid blocks, sometimes at the edge or anywhere
  function automatic item_t rand_beat();
    item_t       b;
    int unsigned roll;
    int unsigned n;
    n    = eff_count();
    roll = $urandom_range(0, 99);
    if (roll < 45)      b.operation = OP_ALLOC;
    else if (roll < 70) b.operation = OP_FREE;
    else if (roll < 93) b.operation = OP_MARK;
    else                b.operation = OP_FORMAT;
    roll = $urandom_range(0, 99);
    if (n != 0 && roll < 70)      b.target_block = BLK_W'($urandom_range(0, n - 1));
    else if (n != 0 && roll < 80) b.target_block = BLK_W'(n - $urandom_range(0, 1));
    else                          b.target_block = BLK_W'($urandom);
    return b;
  endfunction

  task automatic queue_op(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
    item_t b;
    b.operation    = op;
    b.target_block = blk;
    queued_ops.push_back(b);
    ops_sent++;
  endtask

  // Wait at a falling edge until every beat is in, answered and the block is idle
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (ops_taken != ops_sent || map_replies.size() != 0 || busy || start);
  endtask

  // One register write per cycle; the caller drops the write enable
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    case (idx)
      REG_BLOCKS:   blk_count_reg = value;
      REG_RESERVED: rsv_count_reg = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // New phase: both registers, plus a write to an unmapped index that must be dropped
  task automatic set_config(logic [CFG_W-1:0] blocks, logic [CFG_W-1:0] reserved);
    wait_quiet();
    write_reg(REG_BLOCKS, blocks);
    write_reg(REG_UNUSED, CFG_W'($urandom));
    write_reg(REG_RESERVED, reserved);
    cfg_we_i <= 1'b0;
    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 60);
    @(posedge clk_i);
  endtask

  // Driver: present the next beat at the falling edge, with random idle bursts
  always @(negedge clk_i) begin
    if (rst_ni && (!start || beat_taken)) begin
      beat_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (queued_ops.size() != 0) begin
        item_i <= queued_ops.pop_front();
        start  <= 1'b1;
        if (idle_on && $urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 12);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted beats, check result beats, watch for hangs
  always @(posedge clk_i) begin : monitor
    result_t want;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (start && !busy) begin
        map_replies.push_back(apply_map_op(item_i));
        op_seen[item_i.operation]++;
        ops_taken++;
        beat_taken = 1'b1;
        moved      = 1'b1;
      end
      if (done_o) begin
        moved = 1'b1;
        if (result_o.status == ST_RANGE)   range_seen++;
        if (result_o.status == ST_NOSPACE) nospace_seen++;
        if (map_replies.size() == 0) begin
          $error("unexpected result beat: status %0d, allocated_block %0d",
                 result_o.status, result_o.allocated_block);
          err_cnt++;
        end else begin
          want = map_replies.pop_front();
          if (result_o.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, result_o.status);
            err_cnt++;
          end
          if (result_o.allocated_block !== want.allocated_block) begin
            $error("allocated_block mismatch: expected %0d, got %0d",
                   want.allocated_block, result_o.allocated_block);
            err_cnt++;
          end
        end
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("block_bitmap_allocator_top test failed");
          $finish;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin : stim
    int unsigned ph;
    int unsigned k;
    int unsigned roll;
    logic [CFG_W-1:0] blocks;
    logic [CFG_W-1:0] reserved;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_pct = 30;

    // Reset defaults: map starts empty, format keeps block 0, ignored target bits
    wait_quiet();
    @(posedge clk_i);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_FREE, 12'd0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_MARK, 12'hFFF);
    queue_op(OP_FREE, 12'hFFF);
    queue_op(OP_ALLOC, 12'hFFF);
    queue_op(OP_FORMAT, 12'hABC);
    queue_op(OP_ALLOC, 12'h555);

    // Zero block count: everything out of range or full, format still ok
    set_config(13'd0, 13'd5);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_FREE, 12'd0);
    queue_op(OP_MARK, 12'hFFF);
    queue_op(OP_FORMAT, '0);

    // Count and reservation far above the map size: format fills the map
    set_config(13'h1FFF, 13'h1FFF);
    queue_op(OP_FORMAT, '0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_FREE, 12'hFFF);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_ALLOC, '0);

    // Single block, nothing reserved; bits above the count must stay unused
    set_config(13'd1, 13'd0);
    queue_op(OP_FORMAT, '0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_ALLOC, '0);
    queue_op(OP_FREE, 12'd1);
    queue_op(OP_MARK, 12'd0);

    // Full map reserved exactly
    set_config(13'd4096, 13'd4096);
    queue_op(OP_FORMAT, '0);
    queue_op(OP_ALLOC, '0);

    // Random phases, each with its own block count and reservation
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0:       blocks = CFG_W'($urandom_range(1, 40));
        1:       blocks = CFG_W'($urandom_range(41, 700));
        2:       blocks = 13'd4096;
        default: blocks = CFG_W'($urandom_range(4097, 8191));
      endcase
      roll = $urandom_range(0, 9);
      if (roll < 6)      reserved = CFG_W'($urandom_range(0, (blocks > 64) ? 64 : blocks));
      else if (roll < 8) reserved = '0;
      else               reserved = CFG_W'($urandom);
      set_config(blocks, reserved);
      if (ph == RAND_PHASES - 1) idle_on = 1'b0;
      queue_op(OP_FORMAT, BLK_W'($urandom));
      for (k = 1; k < PHASE_OPS; k++) queued_ops.push_back(rand_beat());
      ops_sent += PHASE_OPS - 1;
    end

    // Drain, then leave room for any stray beat
    wait_quiet();
    repeat (80) @(posedge clk_i);

    $display("Covered %0d allocates, %0d frees, %0d marks, %0d formats over %0d phases;",
             op_seen[OP_ALLOC], op_seen[OP_FREE], op_seen[OP_MARK], op_seen[OP_FORMAT],
             RAND_PHASES + 5);
    $display("saw %0d out-of-range and %0d no-space replies, %0d mismatches.",
             range_seen, nospace_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("block_bitmap_allocator_top test passed");
    end else begin
      $display("block_bitmap_allocator_top test failed");
    end
    $finish;
  end

endmodule

// ----- block_bitmap_allocator_top.f -----
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_dpath.sv
rtl/core/block_bitmap_allocator_top.sv
rtl/core/bba_checker.sv
test/tb_block_bitmap_allocator_top.sv
